// ===== src/pfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  localparam int NUM_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;

  localparam int SLOT_W = 4;
  localparam int AMT_W  = 16;
  localparam int IDX_W  = $clog2(NUM_PARTITIONS);
  localparam int CMP_W  = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  localparam int REG_FIT_POLICY = 0;

  typedef enum logic [1:0] {
    POLICY_FIRST = 2'd0,
    POLICY_BEST  = 2'd1,
    POLICY_WORST = 2'd2
  } policy_e;

  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_ALLOC = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ALLOC,
    CMD_DROP
  } cmd_kind_e;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount_kb;
  } in_word_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] chosen_slot;
    logic [AMT_W-1:0]  left_kb;
  } out_word_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [AMT_W-1:0] amount;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/pfa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Decodes input words into commands and queues them for the back end.
module pfa_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pfa_pkg::in_word_t in_word_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_pop_i,
  output pfa_pkg::cmd_t          cmd_o
);

  pfa_pkg::cmd_t cmd_in;
  logic [31:0]   slot_ext;
  pfa_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  always_comb begin
    slot_ext      = 32'(in_word_i.slot);
    cmd_in.idx    = slot_ext[pfa_pkg::IDX_W-1:0];
    cmd_in.amount = in_word_i.amount_kb;
    if (in_word_i.action == pfa_pkg::ACT_ALLOC) begin
      cmd_in.kind = pfa_pkg::CMD_ALLOC;
    end else if (slot_ext >= 32'(pfa_pkg::NUM_PARTITIONS)) begin
      cmd_in.kind = pfa_pkg::CMD_DROP;
    end else begin
      cmd_in.kind = pfa_pkg::CMD_LOAD;
    end
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Holds the free-size table, scans it one entry per cycle, writes back.
module pfa_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pfa_pkg::policy_e   policy_i,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_pop_o,
  input  wire pfa_pkg::cmd_t      cmd_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pfa_pkg::out_word_t      out_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e                         state_q;
  pfa_pkg::cmd_t                  cmd_q;
  logic [pfa_pkg::IDX_W-1:0]      cnt_q;
  logic                           found_q;
  logic [pfa_pkg::IDX_W-1:0]      pick_q;
  logic [pfa_pkg::SIZE_BITS-1:0]  best_q;
  logic                           out_valid_q, out_valid_d;
  pfa_pkg::out_word_t             out_q;

  logic [pfa_pkg::SIZE_BITS-1:0]  table_q [pfa_pkg::NUM_PARTITIONS];

  logic [pfa_pkg::SIZE_BITS-1:0]  entry;
  logic [pfa_pkg::CMP_W-1:0]      entry_ext, amt_ext, left_w;
  logic [pfa_pkg::SIZE_BITS-1:0]  left;
  logic                           fits, take;
  logic                           out_free;
  logic                           fin_go;
  logic                           res_granted;
  logic [pfa_pkg::IDX_W-1:0]      res_idx;
  logic [pfa_pkg::SIZE_BITS-1:0]  res_left;
  logic [31:0]                    idx_ext, left_ext;
  pfa_pkg::out_word_t             res_word;

  assign entry     = table_q[cnt_q];
  assign entry_ext = pfa_pkg::CMP_W'(entry);
  assign amt_ext   = pfa_pkg::CMP_W'(cmd_q.amount);
  assign fits      = (entry_ext >= amt_ext);
  assign left_w    = entry_ext - amt_ext;
  assign left      = left_w[pfa_pkg::SIZE_BITS-1:0];

  always_comb begin
    unique case (policy_i)
      pfa_pkg::POLICY_BEST:  take = fits && (!found_q || (left < best_q));
      pfa_pkg::POLICY_WORST: take = fits && (!found_q || (left > best_q));
      default:               take = fits && !found_q;
    endcase
  end

  // Result of the command held in cmd_q.
  always_comb begin
    res_granted = 1'b0;
    res_idx     = '0;
    res_left    = '0;
    unique case (cmd_q.kind)
      pfa_pkg::CMD_LOAD: begin
        res_granted = 1'b1;
        res_idx     = cmd_q.idx;
        res_left    = amt_ext[pfa_pkg::SIZE_BITS-1:0];
      end
      pfa_pkg::CMD_ALLOC: begin
        res_granted = found_q;
        res_idx     = found_q ? pick_q : '0;
        res_left    = found_q ? best_q : '0;
      end
      default: begin
        res_granted = 1'b0;
      end
    endcase
    idx_ext              = 32'(res_idx);
    left_ext             = 32'(res_left);
    res_word.granted     = res_granted;
    res_word.chosen_slot = idx_ext[pfa_pkg::SLOT_W-1:0];
    res_word.left_kb     = left_ext[pfa_pkg::AMT_W-1:0];
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fin_go      = (state_q == ST_FIN) && out_free;
  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      pick_q      <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            cnt_q   <= '0;
            found_q <= 1'b0;
            state_q <= (cmd_i.kind == pfa_pkg::CMD_ALLOC) ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          if (take) begin
            found_q <= 1'b1;
            pick_q  <= cnt_q;
            best_q  <= left;
          end
          if (cnt_q == pfa_pkg::IDX_W'(pfa_pkg::NUM_PARTITIONS - 1)) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_q   <= res_word;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pfa_pkg::NUM_PARTITIONS; i++) begin
        table_q[i] <= '0;
      end
    end else if (fin_go && res_granted) begin
      table_q[res_idx] <= res_left;
    end
  end

endmodule

`default_nettype wire

// ===== src/partition_fit_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fixed-partition allocator: first / best / worst fit over a free-size table.
// Path: a load word passes the front queue, cmd_q and the output register;
//   an allocate word also passes the scan over all NUM_PARTITIONS entries.
// Rate: the back end takes a new command only when idle, after the last one's
//   result is registered; the scan engine compares one table entry per cycle.
// Reset (async, active low): table all zero, policy first fit, queue empty.
module partition_fit_allocator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pfa_pkg::in_word_t  in_word_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pfa_pkg::out_word_t      out_word_o,
  // APB-style register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Register index is paddr[2]; fit_policy sits at byte address 0.
  logic [1:0]        policy_q;
  logic              reg_hit;
  logic              cmd_valid;
  logic              cmd_pop;
  pfa_pkg::cmd_t     cmd;
  pfa_pkg::policy_e  policy;

  assign pready  = 1'b1;
  assign reg_hit = (32'(paddr[2]) == 32'(pfa_pkg::REG_FIT_POLICY));
  assign prdata  = reg_hit ? 32'(policy_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pfa_pkg::POLICY_FIRST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      policy_q <= pwdata[1:0];
    end
  end

  // Unused code 3 falls through to first fit inside the scan engine.
  assign policy = pfa_pkg::policy_e'(policy_q);

  // Front: decode and queue words so the input side can run ahead.
  pfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // Back: table, scan, write-back and output register.
  pfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .policy_i    (policy),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
